FILE: rtl/mwg_pkg.sv
`default_nettype none

package mwg_pkg;

    localparam int WAVE_LEN  = 32;
    localparam int TICK_W    = 16;
    localparam int MODE_W    = 2;
    localparam int DAC_W     = 8;

    localparam logic [MODE_W-1:0] MODE_SINE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRI  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RAMP = 2'd2;

    localparam int TRI_PERIOD  = 510;
    localparam int TRI_PEAK    = 255;
    localparam int RAMP_PERIOD = 255;

    localparam logic [TICK_W-1:0] TICKS_RESET = 16'd1000;

    typedef enum logic [0:0] {
        CFG_WAVE_MODE        = 1'b0,
        CFG_TICKS_PER_SAMPLE = 1'b1
    } t_cfg_reg;

    function automatic logic [DAC_W-1:0] sine_lut(input logic [4:0] idx);
        logic [DAC_W-1:0] v;
        unique case (idx)
            5'd0:  v = 8'd127;
            5'd1:  v = 8'd151;
            5'd2:  v = 8'd175;
            5'd3:  v = 8'd197;
            5'd4:  v = 8'd216;
            5'd5:  v = 8'd232;
            5'd6:  v = 8'd244;
            5'd7:  v = 8'd251;
            5'd8:  v = 8'd254;
            5'd9:  v = 8'd251;
            5'd10: v = 8'd244;
            5'd11: v = 8'd232;
            5'd12: v = 8'd216;
            5'd13: v = 8'd197;
            5'd14: v = 8'd175;
            5'd15: v = 8'd151;
            5'd16: v = 8'd127;
            5'd17: v = 8'd102;
            5'd18: v = 8'd78;
            5'd19: v = 8'd56;
            5'd20: v = 8'd37;
            5'd21: v = 8'd21;
            5'd22: v = 8'd9;
            5'd23: v = 8'd2;
            5'd24: v = 8'd0;
            5'd25: v = 8'd2;
            5'd26: v = 8'd9;
            5'd27: v = 8'd21;
            5'd28: v = 8'd37;
            5'd29: v = 8'd56;
            5'd30: v = 8'd78;
            5'd31: v = 8'd102;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/multi_waveform_generator.sv
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        sink       i_in_valid / o_in_ready    i_restart
// out       source     o_out_valid / i_out_ready  o_dac_value
// cfg       sink       i_cfg_we                   i_cfg_index, i_cfg_data
//
// One tick is accepted per cycle while o_in_ready is high; any sample it makes
// is registered in the output register, or in the skid stage while the output
// stalls. Phase and prescaler sit in a one-entry state memory read every
// cycle; the last write is forwarded past the registered read. Reset clears
// the state through a valid bit, no sweep. Ticks keep being accepted while
// one sample waits; o_in_ready drops only when output and skid both hold one.

module multi_waveform_generator
    import mwg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_restart,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [DAC_W-1:0]       o_dac_value,
    input  wire logic              i_cfg_we,
    input  wire logic [0:0]        i_cfg_index,
    input  wire logic [TICK_W-1:0] i_cfg_data
);

    localparam int MAX_PERIOD = (SINE_TABLE_DEPTH > TRI_PERIOD) ? SINE_TABLE_DEPTH : TRI_PERIOD;
    localparam int PH_W       = $clog2(MAX_PERIOD);
    localparam int PER_W      = PH_W + 1;
    localparam int ST_W       = PH_W + TICK_W;
    localparam int X_W        = PH_W + $clog2(WAVE_LEN);
    localparam int SIN_SHIFT  = X_W + $clog2(SINE_TABLE_DEPTH);
    localparam longint unsigned SIN_MUL =
        ((64'd1 << SIN_SHIFT) + SINE_TABLE_DEPTH - 1) / SINE_TABLE_DEPTH;
    localparam int M_W        = SIN_SHIFT + 1;
    localparam int P_W        = X_W + M_W;
    localparam int IDX_W      = $clog2(WAVE_LEN);

    localparam logic [PER_W-1:0] SINE_PER = PER_W'(SINE_TABLE_DEPTH);
    localparam logic [PER_W-1:0] TRI_PER  = PER_W'(TRI_PERIOD);
    localparam logic [PER_W-1:0] RAMP_PER = PER_W'(RAMP_PERIOD);
    localparam logic [PH_W-1:0]  TRI_TOP  = PH_W'(TRI_PEAK);
    localparam logic [PH_W-1:0]  TRI_SUM  = PH_W'(TRI_PERIOD);
    localparam logic [M_W-1:0]   MUL_K    = M_W'(SIN_MUL);

    // configuration
    logic [MODE_W-1:0] r_wave_mode;
    logic [TICK_W-1:0] r_tps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_mode <= MODE_SINE;
            r_tps       <= TICKS_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_WAVE_MODE:        r_wave_mode <= i_cfg_data[MODE_W-1:0];
                CFG_TICKS_PER_SAMPLE: r_tps       <= i_cfg_data;
                default:              r_tps       <= r_tps;
            endcase
        end
    end

    // state memory: {phase, tick}
    logic [ST_W-1:0] r_state_mem [1];
    logic [ST_W-1:0] r_rd_data;
    logic            r_rd_valid;
    logic            r_state_valid;
    logic            r_fwd_hit;
    logic [ST_W-1:0] r_fwd_data;
    logic [ST_W-1:0] w_cur;
    logic [ST_W-1:0] n_state;

    logic w_acc;
    logic w_emit;
    logic w_buf_full;

    assign o_in_ready = !w_buf_full;
    assign w_acc      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_state_mem[0] <= n_state;
        end
        r_rd_data  <= r_state_mem[0];
        r_fwd_data <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_valid <= 1'b0;
            r_rd_valid    <= 1'b0;
            r_fwd_hit     <= 1'b0;
        end else begin
            if (w_acc) begin
                r_state_valid <= 1'b1;
            end
            r_rd_valid <= r_state_valid;
            r_fwd_hit  <= w_acc;
        end
    end

    always_comb begin
        priority if (r_fwd_hit) begin
            w_cur = r_fwd_data;
        end else if (r_rd_valid) begin
            w_cur = r_rd_data;
        end else begin
            w_cur = '0;
        end
    end

    logic [PH_W-1:0]   w_cur_phase;
    logic [TICK_W-1:0] w_cur_tick;
    logic [TICK_W-1:0] w_tick_inc;
    logic [TICK_W-1:0] w_limit;
    logic [PER_W-1:0]  w_period;
    logic [PH_W-1:0]   w_ph;
    logic [PER_W-1:0]  w_ph_next;
    logic [PH_W-1:0]   w_phase_new;
    logic [X_W-1:0]    w_x;
    logic [P_W-1:0]    w_prod;
    logic [IDX_W-1:0]  w_sin_idx;
    logic [DAC_W-1:0]  w_sample;
    logic [PH_W-1:0]   w_tri_fall;

    assign w_cur_phase = w_cur[ST_W-1:TICK_W];
    assign w_cur_tick  = w_cur[TICK_W-1:0];
    assign w_tick_inc  = w_cur_tick + 16'd1;
    assign w_limit     = (r_tps == '0) ? 16'd1 : r_tps;

    always_comb begin
        unique case (r_wave_mode)
            MODE_TRI:  w_period = TRI_PER;
            MODE_RAMP: w_period = RAMP_PER;
            default:   w_period = SINE_PER;
        endcase
    end

    // fall back to phase zero when the phase is not below the mode's period
    assign w_ph        = ({1'b0, w_cur_phase} < w_period) ? w_cur_phase : '0;
    assign w_ph_next   = {1'b0, w_ph} + 1'b1;
    assign w_phase_new = (w_ph_next >= w_period) ? '0 : w_ph_next[PH_W-1:0];

    // table index = phase * 32 / depth, by reciprocal multiply
    assign w_x       = {w_ph, {IDX_W{1'b0}}};
    assign w_prod    = P_W'(w_x) * P_W'(MUL_K);
    assign w_sin_idx = w_prod[SIN_SHIFT +: IDX_W];
    assign w_tri_fall = TRI_SUM - w_ph;

    always_comb begin
        unique case (r_wave_mode)
            MODE_TRI:  w_sample = (w_ph < TRI_TOP) ? w_ph[DAC_W-1:0] : w_tri_fall[DAC_W-1:0];
            MODE_RAMP: w_sample = w_ph[DAC_W-1:0];
            default:   w_sample = sine_lut(w_sin_idx);
        endcase
    end

    always_comb begin
        w_emit  = 1'b0;
        n_state = w_cur;
        priority if (i_restart) begin
            n_state = '0;
        end else if (w_tick_inc != '0 && w_tick_inc < w_limit) begin
            n_state = {w_cur_phase, w_tick_inc};
        end else begin
            w_emit  = w_acc;
            n_state = {w_phase_new, {TICK_W{1'b0}}};
        end
    end

    mwg_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_emit),
        .i_data  (w_sample),
        .o_full  (w_buf_full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_dac_value)
    );

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_restart) |=> (w_cur_phase == '0 && w_cur_tick == '0))
        else $error("restart did not clear phase and prescaler");

    a_restart_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_restart) |-> !w_emit)
        else $error("sample emitted on restart tick");

    a_fast_prescale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !i_restart && r_tps <= 16'd1) |-> w_emit)
        else $error("missing sample with prescale of one");

    a_stall_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no pending output");

endmodule

`default_nettype wire

FILE: rtl/mwg_out_buf.sv
`default_nettype none

module mwg_out_buf
    import mwg_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire logic [DAC_W-1:0] i_data,
    output logic                  o_full,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [DAC_W-1:0]      o_data
);

    logic             r_out_valid, n_out_valid;
    logic [DAC_W-1:0] r_out_data,  n_out_data;
    logic             r_skid_valid, n_skid_valid;
    logic [DAC_W-1:0] r_skid_data,  n_skid_data;
    logic             w_take;

    assign w_take = r_out_valid && i_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (w_take) begin
            if (r_skid_valid) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else if (i_load) begin
                n_out_data = i_data;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (i_load) begin
            if (!r_out_valid) begin
                n_out_valid = 1'b1;
                n_out_data  = i_data;
            end else begin
                // park the new transaction while the output stalls
                n_skid_valid = 1'b1;
                n_skid_data  = i_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output entry");

    a_no_load_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_load)
        else $error("load while skid stage is occupied");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_ready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry did not move to output");

endmodule

`default_nettype wire

FILE: test/multi_waveform_generator_tb.sv
`default_nettype none

module multi_waveform_generator_tb;
    import mwg_pkg::*;

    localparam int SINE_DEPTH   = 32;
    localparam int RANDOM_ITEMS = 400;
    localparam int SETTLE       = 4;
    localparam int DRAIN        = 8;
    localparam int TIMEOUT      = 4_000_000;

    localparam logic [MODE_W-1:0] MODE_ALT_SINE = 2'd3;

    // Sine samples, entry 0 in the low byte.
    localparam logic [WAVE_LEN*8-1:0] SINE_PACK = {
        8'd102, 8'd78,  8'd56,  8'd37,  8'd21,  8'd9,   8'd2,   8'd0,
        8'd2,   8'd9,   8'd21,  8'd37,  8'd56,  8'd78,  8'd102, 8'd127,
        8'd151, 8'd175, 8'd197, 8'd216, 8'd232, 8'd244, 8'd251, 8'd254,
        8'd251, 8'd244, 8'd232, 8'd216, 8'd197, 8'd175, 8'd151, 8'd127
    };

    typedef enum logic {ROW_CFG, ROW_TICK} t_row_kind;
    typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BURSTY} t_rx_style;

    typedef struct packed {
        t_row_kind         kind;
        t_cfg_reg          reg_sel;
        logic [TICK_W-1:0] data;
        logic              restart;
        logic              typed;
        logic [DAC_W-1:0]  want;
    } t_dir_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_restart;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [DAC_W-1:0]  o_dac_value;
    logic              i_cfg_we;
    logic [0:0]        i_cfg_index;
    logic [TICK_W-1:0] i_cfg_data;

    // Side info travelling with the tick under drive.
    logic              drv_typed;
    logic [DAC_W-1:0]  drv_want;

    logic [MODE_W-1:0] pred_mode;
    logic [TICK_W-1:0] pred_tps;
    int                pred_phase;
    logic [TICK_W-1:0] pred_ticks;
    logic [DAC_W-1:0]  exp_samples[$];

    int errors;
    int n_ticks;
    int n_samples;
    int n_writes;
    int burst_left;
    int rx_left;
    t_rx_style rx_style;

    t_dir_row dir_rows[$];

    multi_waveform_generator #(
        .SINE_TABLE_DEPTH(SINE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_restart  (i_restart),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_dac_value(o_dac_value),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Advance the waveform by one tick; returns 1 when a sample comes out.
    function automatic logic compute_sample(input logic restart,
                                            output logic [DAC_W-1:0] sample);
        int limit;
        int period;
        int ph;
        sample = '0;
        if (restart) begin
            pred_phase = 0;
            pred_ticks = '0;
            return 1'b0;
        end
        limit = (pred_tps == 0) ? 1 : int'(pred_tps);
        pred_ticks = pred_ticks + 1'b1;
        if (pred_ticks != 0 && int'(pred_ticks) < limit)
            return 1'b0;
        pred_ticks = '0;
        case (pred_mode)
            MODE_TRI:  period = TRI_PERIOD;
            MODE_RAMP: period = RAMP_PERIOD;
            default:   period = SINE_DEPTH;
        endcase
        // A phase left over from a longer waveform restarts the period.
        ph = (pred_phase < period) ? pred_phase : 0;
        case (pred_mode)
            MODE_TRI:  sample = (ph < TRI_PEAK) ? ph[7:0] : 8'(TRI_PERIOD - ph);
            MODE_RAMP: sample = ph[7:0];
            default:   sample = SINE_PACK[((ph * WAVE_LEN / SINE_DEPTH) % WAVE_LEN) * 8 +: 8];
        endcase
        ph = ph + 1;
        pred_phase = (ph >= period) ? 0 : ph;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        logic [DAC_W-1:0] sample;
        logic             fired;
        if (!i_rst_n) begin
            pred_mode  = MODE_SINE;
            pred_tps   = TICKS_RESET;
            pred_phase = 0;
            pred_ticks = '0;
            exp_samples.delete();
        end else begin
            if (o_out_valid === 1'b1 && i_out_ready) begin
                n_samples++;
                if (exp_samples.size() == 0) begin
                    errors++;
                    $display("%0t: dac_value with none expected, expected none, got %0d",
                             $time, o_dac_value);
                end else begin
                    sample = exp_samples.pop_front();
                    if (o_dac_value !== sample) begin
                        errors++;
                        $display("%0t: dac_value mismatch, expected %0d, got %0d",
                                 $time, sample, o_dac_value);
                    end
                end
            end
            if (i_cfg_we) begin
                n_writes++;
                if (i_cfg_index == CFG_WAVE_MODE)
                    pred_mode = i_cfg_data[MODE_W-1:0];
                else
                    pred_tps = i_cfg_data;
            end
            if (i_in_valid && o_in_ready === 1'b1) begin
                n_ticks++;
                fired = compute_sample(i_restart, sample);
                if (drv_typed)
                    exp_samples.push_back(drv_want);
                else if (fired)
                    exp_samples.push_back(sample);
            end
        end
    end

    // Receiver: switch at random between stall styles.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_style = t_rx_style'($urandom_range(0, 3));
            rx_left  = $urandom_range(20, 300);
        end
        rx_left--;
        case (rx_style)
            RX_OPEN:  i_out_ready <= 1'b1;
            RX_LIGHT: i_out_ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: i_out_ready <= ($urandom_range(0, 3) == 0);
            default:  i_out_ready <= ((rx_left % 8) < 3);
        endcase
    end

    function automatic t_dir_row cfg_row(input t_cfg_reg sel, input logic [TICK_W-1:0] value);
        t_dir_row r;
        r = '0;
        r.kind    = ROW_CFG;
        r.reg_sel = sel;
        r.data    = value;
        return r;
    endfunction

    function automatic t_dir_row tick_row(input logic restart, input logic typed,
                                          input logic [DAC_W-1:0] want);
        t_dir_row r;
        r = '0;
        r.kind    = ROW_TICK;
        r.restart = restart;
        r.typed   = typed;
        r.want    = want;
        return r;
    endfunction

    task automatic send_tick(input logic restart, input logic typed,
                             input logic [DAC_W-1:0] want);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_restart  <= restart;
        drv_typed  <= typed;
        drv_want   <= want;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
    endtask

    // Write only with the block idle: no tick pending, every sample drained.
    task automatic write_reg(input t_cfg_reg sel, input logic [TICK_W-1:0] value);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (exp_samples.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int rand_items;
        int rst_odds;
        int len;
        logic [TICK_W-1:0] tps;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_restart   = 1'b0;
        i_out_ready = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_WAVE_MODE;
        i_cfg_data  = '0;
        drv_typed   = 1'b0;
        drv_want    = '0;
        errors      = 0;
        n_ticks     = 0;
        n_samples   = 0;
        n_writes    = 0;
        burst_left  = 0;
        rx_left     = 0;
        rand_items  = 0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        dir_rows.push_back(tick_row(1'b0, 1'b0, 8'd0));
        dir_rows.push_back(tick_row(1'b1, 1'b0, 8'd0));
        dir_rows.push_back(cfg_row(CFG_TICKS_PER_SAMPLE, 16'd0));
        dir_rows.push_back(tick_row(1'b0, 1'b1, 8'd127));
        dir_rows.push_back(tick_row(1'b0, 1'b1, 8'd151));
        dir_rows.push_back(tick_row(1'b1, 1'b0, 8'd0));
        dir_rows.push_back(tick_row(1'b0, 1'b1, 8'd127));
        dir_rows.push_back(cfg_row(CFG_WAVE_MODE, 16'(MODE_RAMP)));
        dir_rows.push_back(tick_row(1'b0, 1'b1, 8'd1));
        dir_rows.push_back(cfg_row(CFG_WAVE_MODE, 16'(MODE_ALT_SINE)));
        dir_rows.push_back(tick_row(1'b0, 1'b1, 8'd175));
        dir_rows.push_back(cfg_row(CFG_WAVE_MODE, 16'(MODE_TRI)));
        dir_rows.push_back(tick_row(1'b0, 1'b1, 8'd3));
        dir_rows.push_back(cfg_row(CFG_TICKS_PER_SAMPLE, 16'hFFFF));
        dir_rows.push_back(tick_row(1'b0, 1'b0, 8'd0));
        dir_rows.push_back(tick_row(1'b0, 1'b0, 8'd0));
        dir_rows.push_back(cfg_row(CFG_TICKS_PER_SAMPLE, 16'd1));
        dir_rows.push_back(tick_row(1'b0, 1'b0, 8'd0));
        dir_rows.push_back(cfg_row(CFG_TICKS_PER_SAMPLE, 16'd3));
        dir_rows.push_back(tick_row(1'b0, 1'b0, 8'd0));
        dir_rows.push_back(tick_row(1'b0, 1'b0, 8'd0));
        dir_rows.push_back(tick_row(1'b0, 1'b0, 8'd0));

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG)
                write_reg(dir_rows[k].reg_sel, dir_rows[k].data);
            else
                send_tick(dir_rows[k].restart, dir_rows[k].typed, dir_rows[k].want);
        end

        // Full periods: triangle peak and wrap, sine after a long phase,
        // ramp top and wrap.
        write_reg(CFG_WAVE_MODE, 16'(MODE_TRI));
        write_reg(CFG_TICKS_PER_SAMPLE, 16'd1);
        repeat (600) send_tick(1'b0, 1'b0, 8'd0);
        write_reg(CFG_WAVE_MODE, 16'(MODE_SINE));
        repeat (40) send_tick(1'b0, 1'b0, 8'd0);
        write_reg(CFG_WAVE_MODE, 16'(MODE_RAMP));
        repeat (300) send_tick(1'b0, 1'b0, 8'd0);

        while (rand_items < RANDOM_ITEMS) begin
            // Upper data bits on a mode write are junk the block must drop.
            write_reg(CFG_WAVE_MODE, 16'($urandom_range(0, 65535)));
            case ($urandom_range(0, 9))
                0:             tps = 16'd0;
                1, 2, 3, 4, 5: tps = 16'd1;
                6, 7:          tps = 16'($urandom_range(2, 4));
                8:             tps = 16'($urandom_range(5, 24));
                default:       tps = 16'($urandom_range(25, 60));
            endcase
            write_reg(CFG_TICKS_PER_SAMPLE, tps);
            case ($urandom_range(0, 2))
                0:       rst_odds = 0;
                1:       rst_odds = 31;
                default: rst_odds = 5;
            endcase
            len = $urandom_range(30, 200);
            repeat (len) begin
                send_tick((rst_odds != 0) && ($urandom_range(0, rst_odds) == 0),
                          1'b0, 8'd0);
                rand_items++;
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (exp_samples.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);

        $display("run covered %0d ticks and %0d samples over %0d register writes",
                 n_ticks, n_samples, n_writes);
        $display("all four modes, prescale 0 to 65535, restarts, %0d mismatches", errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #(TIMEOUT);
        $display("timeout with %0d samples outstanding", exp_samples.size());
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
